@@ rtl/core/tga_pkg.sv @@
// shared types and constants for the tga stream decoder
// no dependencies
package tga_pkg;
  localparam int DIM_BITS = 15;
  localparam logic [15:0] MAX_DIM = 16'((1 << DIM_BITS) - 1);

  typedef struct packed {
    logic [7:0] file_byte;
    logic       file_start;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [14:0] start_col;
    logic [14:0] start_row;
    logic [7:0]  run_length;
    logic [31:0] pixel_word;
    logic [2:0]  pixel_bytes;
    logic        image_done;
  } out_item_t;

  localparam logic [1:0] ST_SPAN = 2'd0;
  localparam logic [1:0] ST_BAD_HDR = 2'd1;
  localparam logic [1:0] ST_OVERRUN = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE, PH_HEADER, PH_SKIP, PH_PACKET, PH_PIXEL, PH_ADV
  } phase_t;

  typedef struct packed {
    logic       take;       // byte accepted
    logic       restart;
    logic       adv;        // cursor step cycle
    phase_t     phase;
  } cmd_t;

  typedef struct packed {
    logic       hdr_last;   // header byte 17 reached
    logic       hdr_ok;
    logic       id_zero;    // id length zero
    logic       id_last;    // last id byte
    logic       rle;
    logic       overrun;
    logic       pix_end;    // byte completes pixel
    logic       packet_end;
    logic       done;
    logic       adv_last;   // last cursor step
  } sts_t;
endpackage

@@ rtl/core/tga_ctrl.sv @@
// phase controller for the tga decoder
// depends on tga_pkg
module tga_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  tga_pkg::in_item_t in_data,
  output logic          in_ready,
  input  logic          out_free,
  input  tga_pkg::sts_t sts,
  output tga_pkg::cmd_t cmd,
  output logic          emit_err,
  output logic [1:0]    err_code,
  output logic          emit_span
);
  import tga_pkg::*;
  phase_t ph_r, ph_nxt;
  logic take;

  always_ff @(posedge clk) begin
    if (!rst_n) ph_r <= PH_IDLE;
    else ph_r <= ph_nxt;
  end

  always_comb begin
    in_ready = (ph_r != PH_ADV) && out_free;
    take = in_valid && in_ready;
    cmd.take = take;
    cmd.restart = take && in_data.file_start;
    cmd.adv = (ph_r == PH_ADV);
    cmd.phase = in_data.file_start ? PH_HEADER : ph_r;
    ph_nxt = ph_r;
    emit_err = 1'b0;
    err_code = ST_BAD_HDR;
    emit_span = 1'b0;
    if (ph_r == PH_ADV) begin
      if (sts.adv_last) begin
        emit_span = 1'b1;
        if (sts.done) ph_nxt = PH_IDLE;
        else if (sts.rle && sts.packet_end) ph_nxt = PH_PACKET;
        else ph_nxt = PH_PIXEL;
      end
    end else if (take) begin
      case (cmd.phase)
        PH_HEADER: begin
          ph_nxt = PH_HEADER;
          if (sts.hdr_last && !cmd.restart) begin
            if (!sts.hdr_ok) begin
              emit_err = 1'b1;
              ph_nxt = PH_IDLE;
            end else if (!sts.id_zero) ph_nxt = PH_SKIP;
            else ph_nxt = sts.rle ? PH_PACKET : PH_PIXEL;
          end
        end
        PH_SKIP: if (sts.id_last) ph_nxt = sts.rle ? PH_PACKET : PH_PIXEL;
        PH_PACKET: begin
          if (sts.overrun) begin
            emit_err = 1'b1;
            err_code = ST_OVERRUN;
            ph_nxt = PH_IDLE;
          end else ph_nxt = PH_PIXEL;
        end
        PH_PIXEL: if (sts.pix_end) ph_nxt = PH_ADV;
        default: ph_nxt = ph_r;
      endcase
    end
  end
endmodule

@@ rtl/core/tga_dpath.sv @@
// header registers, pixel gathering and cursor datapath
// depends on tga_pkg
module tga_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  tga_pkg::in_item_t in_data,
  input  tga_pkg::cmd_t     cmd,
  output tga_pkg::sts_t     sts,
  output tga_pkg::out_item_t span
);
  import tga_pkg::*;
  logic [4:0]  hcnt_r;
  logic [7:0]  idl_r, type_r, bpp_r, pleft_r;
  logic [15:0] w_r, h_r;
  logic [1:0]  flip_r, bip_r;
  logic        rep_r;
  logic [23:0] gath_r;
  logic [14:0] cx_r, cy_r;
  logic [29:0] pdone_r;
  logic [31:0] total_r;
  logic [31:0] word_r;
  logic [7:0]  n_r;
  logic [14:0] col_r, row_r;
  logic [15:0] pos_r;
  logic [2:0]  dstep_r;
  logic [7:0]  b;
  logic [2:0]  bpb;
  logic        rle, vtype, vbpb;
  logic [7:0]  n_sel;
  logic [30:0] pd_sum;
  logic [30:0] pk_sum;
  logic [31:0] word_nxt;
  logic [22:0] div_sub, div_diff;
  logic        div_ge;
  logic [15:0] div_rem;

  assign b = in_data.file_byte;
  assign bpb = bpp_r[5:3];
  assign rle = (type_r == 8'd10) || (type_r == 8'd11);
  assign vtype = (type_r == 8'd2) || (type_r == 8'd3) || rle;
  assign vbpb = (bpp_r[7:6] == 2'b00) && ((bpb == 3'd1) || (bpb == 3'd3) || (bpb == 3'd4));
  assign n_sel = (rle && rep_r) ? pleft_r : 8'd1;
  assign pk_sum = {1'b0, pdone_r} + 31'({1'b0, b[6:0]} + 8'd1);
  assign pd_sum = {1'b0, pdone_r} + {23'd0, n_sel};
  assign div_sub = {7'd0, w_r} << dstep_r;
  assign div_ge = {7'd0, pos_r} >= div_sub;
  assign div_diff = {7'd0, pos_r} - div_sub;
  assign div_rem = div_ge ? div_diff[15:0] : pos_r;

  always_comb begin
    word_nxt = {8'hff, gath_r};
    case (bip_r)
      2'd0: word_nxt[7:0] = b;
      2'd1: word_nxt[15:8] = b;
      2'd2: word_nxt[23:16] = b;
      default: word_nxt[31:24] = b;
    endcase
    sts.hdr_last = (hcnt_r == 5'd17);
    sts.hdr_ok = (w_r != 16'd0) && (w_r <= MAX_DIM) && (h_r != 16'd0) && (h_r <= MAX_DIM)
                 && vbpb && vtype && !idl_r[7];
    sts.id_zero = (idl_r == 8'd0);
    sts.id_last = (idl_r == 8'd1);
    sts.rle = rle;
    sts.overrun = {1'b0, pk_sum} > total_r;
    sts.pix_end = !(({1'b0, bip_r} + 3'd1) < bpb);
    sts.packet_end = (pleft_r == 8'd0);
    sts.done = {2'b0, pdone_r} >= total_r;
    sts.adv_last = (dstep_r == 3'd0);
    span.status = ST_SPAN;
    span.start_col = col_r;
    span.start_row = row_r;
    span.run_length = n_r;
    span.pixel_word = word_r;
    span.pixel_bytes = bpb;
    span.image_done = sts.done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hcnt_r <= '0; idl_r <= '0; type_r <= '0; w_r <= '0; h_r <= '0; bpp_r <= '0;
      flip_r <= '0; pleft_r <= '0; rep_r <= 1'b0; gath_r <= '1; bip_r <= '0;
      cx_r <= '0; cy_r <= '0; pdone_r <= '0; total_r <= '0; dstep_r <= '0;
    end else if (cmd.adv) begin
      // one quotient bit of (x + run) / width per cycle
      dstep_r <= dstep_r - 3'd1;
      if (div_ge) begin
        pos_r <= div_diff[15:0];
        cy_r <= cy_r + (15'd1 << dstep_r);
      end
      if (dstep_r == 3'd0) cx_r <= div_rem[14:0];
    end else if (cmd.take) begin
      if (cmd.restart) begin
        type_r <= '0; bpp_r <= '0; flip_r <= '0;
        pleft_r <= '0; rep_r <= 1'b0; gath_r <= '1; bip_r <= '0;
        cx_r <= '0; cy_r <= '0; pdone_r <= '0;
        w_r <= '0; h_r <= '0;
        hcnt_r <= 5'd1;
        idl_r <= b;
      end else begin
        case (cmd.phase)
          PH_HEADER: begin
            case (hcnt_r)
              5'd0: idl_r <= b;
              5'd2: type_r <= b;
              5'd12: w_r[7:0] <= b;
              5'd13: w_r[15:8] <= b;
              5'd14: h_r[7:0] <= b;
              5'd15: h_r[15:8] <= b;
              5'd16: bpp_r <= b;
              5'd17: flip_r <= b[5:4];
              default: ;
            endcase
            if (hcnt_r == 5'd16) total_r <= w_r * h_r;
            if (hcnt_r != 5'd17) hcnt_r <= hcnt_r + 5'd1;
          end
          PH_SKIP: idl_r <= idl_r - 8'd1;
          PH_PACKET: begin
            pleft_r <= {1'b0, b[6:0]} + 8'd1;
            rep_r <= b[7];
          end
          PH_PIXEL: begin
            if (!sts.pix_end) begin
              gath_r <= word_nxt[23:0];
              bip_r <= bip_r + 2'd1;
            end else begin
              gath_r <= '1;
              bip_r <= '0;
              word_r <= word_nxt;
              n_r <= n_sel;
              if (rle && rep_r) pleft_r <= '0;
              else if (rle) pleft_r <= pleft_r - 8'd1;
              pdone_r <= pd_sum[29:0];
              pos_r <= {1'b0, cx_r} + {8'd0, n_sel};
              dstep_r <= 3'd7;
              col_r <= flip_r[0] ? 15'(w_r - 16'd1 - {1'b0, cx_r}) : cx_r;
              row_r <= flip_r[1] ? cy_r : 15'(h_r - 16'd1 - {1'b0, cy_r});
            end
          end
          default: ;
        endcase
      end
    end
  end
endmodule

@@ rtl/core/tga_stream_image_decoder_unit.sv @@
// tga stream decoder, top level with output register
// depends on tga_pkg, tga_ctrl, tga_dpath
// One byte is taken per cycle while parsing and the output register is free; the byte that
// completes a pixel is followed by an advance in which the cursor advances by the run modulo
// the image width, one quotient bit per cycle, and the span is loaded into the output register
// on its last step, and no bytes are taken during the advance. Errors are reported with all
// fields but status at zero, after which bytes are ignored until file_start.
module tga_stream_image_decoder_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tga_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tga_pkg::out_item_t out_data
);
  import tga_pkg::*;
  cmd_t cmd;
  sts_t sts;
  logic emit_err, emit_span, out_free;
  logic [1:0] err_code;
  out_item_t span, out_r, out_nxt;
  logic ov_r, ov_nxt;

  assign out_free = !ov_r || out_ready;

  tga_ctrl u_ctrl (.clk, .rst_n, .in_valid, .in_data, .in_ready, .out_free, .sts, .cmd,
                   .emit_err, .err_code, .emit_span);
  tga_dpath u_dpath (.clk, .rst_n, .in_data, .cmd, .sts, .span);

  always_comb begin
    ov_nxt = ov_r && !out_ready;
    out_nxt = out_r;
    if (emit_span) begin
      ov_nxt = 1'b1;
      out_nxt = span;
    end else if (emit_err) begin
      ov_nxt = 1'b1;
      out_nxt = '0;
      out_nxt.status = err_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else ov_r <= ov_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = ov_r;
  assign out_data = out_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !(emit_span || emit_err)) else $error("result overwritten");
  a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
    !(emit_span && emit_err)) else $error("two results at once");
  a_adv_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    emit_span |-> !in_ready) else $error("byte taken during advance");
endmodule

@@ dv/tga_span_checker.sv @@
// span checker for the tga stream decoder: watches both channels, predicts spans and errors
// depends on tga_pkg; failure count is handed to the testbench top
`timescale 1ns / 1ps
module tga_span_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  tga_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  tga_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending_spans,
  output int                 spans_seen,
  output int                 errors_seen
);
  import tga_pkg::*;

  phase_t      ph;
  logic [4:0]  hdr_idx;
  logic [7:0]  id_left;
  logic [7:0]  img_type;
  logic [15:0] img_w;
  logic [15:0] img_h;
  logic [7:0]  bpp;
  logic [1:0]  flips;
  logic [7:0]  pkt_left;
  logic        pkt_rep;
  logic [23:0] gathered;
  logic [1:0]  byte_idx;
  logic [14:0] cur_x;
  logic [14:0] cur_y;
  logic [29:0] px_done;

  out_item_t expected_spans[$];

  function automatic logic is_rle();
    return img_type == 8'd10 || img_type == 8'd11;
  endfunction

  task automatic clear_decoder();
    ph = PH_IDLE; hdr_idx = '0; id_left = '0; img_type = '0; img_w = '0; img_h = '0;
    bpp = '0; flips = '0; pkt_left = '0; pkt_rep = 1'b0; gathered = 24'hFFFFFF;
    byte_idx = '0; cur_x = '0; cur_y = '0; px_done = '0;
  endtask

  task automatic enter_pixels();
    ph = is_rle() ? PH_PACKET : PH_PIXEL;
    pkt_left = '0;
    pkt_rep = 1'b0;
  endtask

  function automatic logic header_ok();
    int bpb;
    bpb = int'(bpp >> 3);
    if (img_w == 0 || img_w > MAX_DIM) return 1'b0;
    if (img_h == 0 || img_h > MAX_DIM) return 1'b0;
    if (bpp >= 8'd128) return 1'b0;
    if (bpb != 1 && bpb != 3 && bpb != 4) return 1'b0;
    if (!(img_type inside {8'd2, 8'd3, 8'd10, 8'd11})) return 1'b0;
    if (id_left >= 8'd128) return 1'b0;
    return 1'b1;
  endfunction

  task automatic push_error(logic [1:0] st);
    out_item_t e;
    e = '0;
    e.status = st;
    expected_spans.push_back(e);
    ph = PH_IDLE;
  endtask

  task automatic decode_byte(in_item_t it);
    logic [7:0]  b;
    int          bpb, k, n, pos;
    longint      total;
    logic [31:0] word;
    out_item_t   e;
    b = it.file_byte;
    if (it.file_start) begin
      clear_decoder();
      ph = PH_HEADER;
    end
    total = longint'(img_w) * longint'(img_h);
    case (ph)
      PH_HEADER: begin
        case (hdr_idx)
          5'd0: id_left = b;
          5'd2: img_type = b;
          5'd12: img_w[7:0] = b;
          5'd13: img_w[15:8] = b;
          5'd14: img_h[7:0] = b;
          5'd15: img_h[15:8] = b;
          5'd16: bpp = b;
          5'd17: flips = b[5:4];
          default: ;
        endcase
        if (hdr_idx == 5'd17) begin
          if (!header_ok()) push_error(ST_BAD_HDR);
          else if (id_left != 0) ph = PH_SKIP;
          else enter_pixels();
        end else begin
          hdr_idx = hdr_idx + 1'b1;
        end
      end
      PH_SKIP: begin
        id_left = id_left - 1'b1;
        if (id_left == 0) enter_pixels();
      end
      PH_PACKET: begin
        n = int'(b & 8'd127) + 1;
        if (longint'(px_done) + n > total) begin
          push_error(ST_OVERRUN);
        end else begin
          pkt_left = 8'(n);
          pkt_rep = b[7];
          ph = PH_PIXEL;
        end
      end
      PH_PIXEL: begin
        bpb = int'(bpp >> 3);
        k = int'(byte_idx);
        if (k + 1 < bpb) begin
          gathered[8*k +: 8] = b;
          byte_idx = byte_idx + 1'b1;
        end else begin
          word = {8'hFF, gathered};
          word[8*k +: 8] = b;
          gathered = 24'hFFFFFF;
          byte_idx = '0;
          n = 1;
          if (is_rle()) begin
            if (pkt_rep) begin
              n = int'(pkt_left);
              pkt_left = '0;
            end else begin
              pkt_left = pkt_left - 1'b1;
            end
          end
          e = '0;
          e.status = ST_SPAN;
          e.start_col = flips[0] ? 15'(img_w - 1 - cur_x) : cur_x;
          e.start_row = flips[1] ? cur_y : 15'(img_h - 1 - cur_y);
          e.run_length = 8'(n);
          e.pixel_word = word;
          e.pixel_bytes = 3'(bpb);
          px_done = px_done + 30'(n);
          e.image_done = longint'(px_done) >= total;
          pos = int'(cur_x) + n;
          cur_y = 15'(cur_y + pos / img_w);
          cur_x = 15'(pos % img_w);
          expected_spans.push_back(e);
          if (e.image_done) ph = PH_IDLE;
          else if (is_rle() && pkt_left == 0) ph = PH_PACKET;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0h actual %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      clear_decoder();
      expected_spans.delete();
      fail_count = 0;
      spans_seen = 0;
      errors_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_spans.size() == 0) begin
          $error("unexpected beat on result channel: %p", out_data);
          fail_count++;
        end else begin
          e = expected_spans.pop_front();
          check_field("status", e.status, out_data.status);
          check_field("start_col", e.start_col, out_data.start_col);
          check_field("start_row", e.start_row, out_data.start_row);
          check_field("run_length", e.run_length, out_data.run_length);
          check_field("pixel_word", e.pixel_word, out_data.pixel_word);
          check_field("pixel_bytes", e.pixel_bytes, out_data.pixel_bytes);
          check_field("image_done", e.image_done, out_data.image_done);
          if (e.status == ST_SPAN) spans_seen++;
          else errors_seen++;
        end
      end
      if (in_valid && in_ready) decode_byte(in_data);
    end
    pending_spans = expected_spans.size();
  end
endmodule

@@ dv/tga_stream_image_decoder_unit_tb.sv @@
// testbench top for the tga stream decoder: drives whole files, broken headers and noise
// depends on tga_pkg, tga_stream_image_decoder_unit and tga_span_checker
`timescale 1ns / 1ps
module tga_stream_image_decoder_unit_tb;
  import tga_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  int        fail_count, pending_spans, spans_seen, errors_seen;
  int        bytes_sent;
  int        send_idle_pct, recv_idle_pct;
  int        quiet_cycles;

  tga_stream_image_decoder_unit dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  tga_span_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending_spans(pending_spans), .spans_seen(spans_seen),
    .errors_seen(errors_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stall
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // valid stays high into the next beat unless the sender idles or drains
  task automatic send_byte(logic [7:0] b, logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{file_byte: b, file_start: first};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_header(logic [7:0] id_len, logic [7:0] ty, logic [15:0] w,
                             logic [15:0] h, logic [7:0] bits, logic [7:0] desc);
    logic [7:0] hb [18];
    for (int i = 0; i < 18; i++) hb[i] = 8'($urandom_range(255));
    hb[0] = id_len; hb[2] = ty; hb[12] = w[7:0]; hb[13] = w[15:8];
    hb[14] = h[7:0]; hb[15] = h[15:8]; hb[16] = bits; hb[17] = desc;
    for (int i = 0; i < 18; i++) send_byte(hb[i], i == 0);
    for (int i = 0; i < id_len; i++) send_byte(8'($urandom_range(255)), 1'b0);
  endtask

  function automatic logic [7:0] pick_bits();
    case ($urandom_range(2))
      0: return 8'd8 + 8'($urandom_range(7));
      1: return 8'd24 + 8'($urandom_range(7));
      default: return 8'd32 + 8'($urandom_range(7));
    endcase
  endfunction

  // whole image; rle packets split randomly, occasionally overlong
  task automatic send_image(logic [7:0] ty, logic [15:0] w, logic [15:0] h,
                            logic [7:0] bits, logic [7:0] id_len, int overrun_pct);
    int total, left, n, bpb;
    logic rep;
    send_header(id_len, ty, w, h, bits, 8'($urandom_range(255)));
    bpb = int'(bits >> 3);
    total = w * h;
    left = total;
    while (left > 0) begin
      if (ty == 8'd10 || ty == 8'd11) begin
        n = $urandom_range(left < 128 ? left : 128, 1);
        rep = 1'($urandom_range(1));
        if ($urandom_range(99) < overrun_pct) begin
          send_byte({rep, 7'($urandom_range(127, left < 128 ? left : 127))}, 1'b0);
          return;
        end
        send_byte({rep, 7'(n - 1)}, 1'b0);
        for (int p = 0; p < (rep ? 1 : n); p++)
          for (int j = 0; j < bpb; j++) send_byte(8'($urandom_range(255)), 1'b0);
      end else begin
        n = 1;
        for (int j = 0; j < bpb; j++) send_byte(8'($urandom_range(255)), 1'b0);
      end
      left -= n;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_spans != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic random_part(int budget);
    int r, stop_at;
    logic [7:0] ty;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(99);
      case ($urandom_range(3))
        0: ty = 8'd2;
        1: ty = 8'd3;
        2: ty = 8'd10;
        default: ty = 8'd11;
      endcase
      if (r < 70) begin
        send_image(ty, 16'($urandom_range(6, 1)), 16'($urandom_range(4, 1)), pick_bits(),
                   $urandom_range(3) == 0 ? 8'($urandom_range(3)) : 8'd0, 10);
      end else if (r < 80) begin
        send_header(8'($urandom_range(255)), 8'($urandom_range(255)),
                    16'($urandom_range(65535)), 16'($urandom_range(65535)),
                    8'($urandom_range(255)), 8'($urandom_range(255)));
      end else if (r < 90) begin
        for (int i = 0; i < 6; i++) send_byte(8'($urandom_range(255)), 1'b0);
      end else begin
        send_header(8'd0, ty, 16'd4, 16'd3, 8'd24, 8'($urandom_range(255)));
        for (int i = 0; i < $urandom_range(10, 1); i++)
          send_byte(8'($urandom_range(255)), 1'b0);
      end
      if ($urandom_range(9) == 0) drain();
    end
  endtask

  initial begin
    in_valid = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    bytes_sent = 0;
    send_idle_pct = 14;
    recv_idle_pct = 74;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: idle bytes, all types and depths, flips, bad headers, overrun, restart
    send_byte(8'hFF, 1'b0);
    send_image(8'd2, 16'd2, 16'd1, 8'd8, 8'd0, 0);
    send_image(8'd3, 16'd1, 16'd1, 8'd32, 8'd1, 0);
    send_image(8'd10, 16'd3, 16'd2, 8'd24, 8'd0, 0);
    send_header(8'd0, 8'd11, 16'd200, 16'd1, 8'd8, 8'h30);
    send_byte(8'd128, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain();
    send_header(8'd0, 8'd11, 16'd2, 16'd2, 8'd8, 8'h10);
    send_byte(8'hFF, 1'b0);
    send_header(8'd0, 8'd2, 16'd0, 16'd1, 8'd8, 8'h00);
    send_header(8'd0, 8'd2, 16'h8000, 16'd1, 8'd8, 8'h00);
    send_header(8'd0, 8'd2, 16'd1, 16'hFFFF, 8'd8, 8'h00);
    send_header(8'd0, 8'd2, 16'd1, 16'd1, 8'd16, 8'h00);
    send_header(8'd0, 8'd2, 16'd1, 16'd1, 8'd160, 8'h00);
    send_header(8'd0, 8'd1, 16'd1, 16'd1, 8'd8, 8'h00);
    send_header(8'd128, 8'd2, 16'd1, 16'd1, 8'd8, 8'h00);
    send_header(8'd0, 8'd3, 16'h7FFF, 16'h7FFF, 8'd8, 8'h20);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h11, 1'b1);
    drain();

    random_part(130);
    drain();
    send_idle_pct = 74;
    recv_idle_pct = 14;
    random_part(130);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_part(130);
    drain();

    $display("covered %0d bytes: %0d pixel spans and %0d error results checked",
             bytes_sent, spans_seen, errors_seen);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
